// ===== hw/rtl/gcdlcm_pkg.sv =====
// gcd/lcm unit package: field widths, default operand width, core status type
// no dependencies
`default_nettype none

package gcdlcm_pkg;

  localparam int FIELD_W           = 32;
  localparam int PRODUCT_W         = 64;
  localparam int OPERAND_WIDTH_DEF = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gcdlcm_core.sv =====
// gcd/lcm iterative core: binary gcd, restoring divide, final multiply
// one shared subtractor serves the gcd reduction and the divide steps
// depends on gcdlcm_pkg
`default_nettype none

module gcdlcm_core #(
  parameter int W = gcdlcm_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [W-1:0]           a_i,
  input  wire logic [W-1:0]           b_i,
  output gcdlcm_pkg::core_stat_t      stat_o,
  output logic      [W-1:0]           gcd_o,
  output logic      [2*W-1:0]         lcm_o
);

  localparam int CntW = $clog2(W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_REDUCE,
    ST_DIVIDE,
    ST_MULT
  } state_e;

  state_e          state_q;
  logic            done_q;
  logic [W-1:0]    a_q;
  logic [W-1:0]    b_q;
  logic [W-1:0]    x_q;
  logic [W-1:0]    y_q;
  logic [W-1:0]    g_q;
  logic [W-1:0]    rem_q;
  logic [CntW-1:0] k_q;
  logic [CntW-1:0] cnt_q;
  logic [2*W-1:0]  prod_q;

  // shared subtract / compare unit
  logic [W:0]      opa;
  logic [W:0]      opb;
  logic [W+1:0]    diff;
  logic            borrow;
  logic [2*W-1:0]  prod_c;

  always_comb begin
    case (state_q)
      ST_REDUCE: begin
        opa = {1'b0, a_q};
        opb = {1'b0, b_q};
      end
      ST_DIVIDE: begin
        opa = {rem_q, x_q[W-1]};
        opb = {1'b0, g_q};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign diff   = {1'b0, opa} - {1'b0, opb};
  assign borrow = diff[W+1];
  assign prod_c = x_q * y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            b_q     <= b_i;
            x_q     <= a_i;
            y_q     <= b_i;
            k_q     <= '0;
            state_q <= ST_STRIP;
          end
        end
        // remove common factors of two
        ST_STRIP: begin
          if (a_q[0] || b_q[0]) begin
            state_q <= ST_REDUCE;
          end else begin
            a_q <= a_q >> 1;
            b_q <= b_q >> 1;
            k_q <= k_q + CntW'(1);
          end
        end
        ST_REDUCE: begin
          if (!a_q[0]) begin
            a_q <= a_q >> 1;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else if (diff == '0) begin
            g_q     <= a_q << k_q;
            rem_q   <= '0;
            cnt_q   <= CntW'(W - 1);
            state_q <= ST_DIVIDE;
          end else if (borrow) begin
            a_q <= b_q;
            b_q <= a_q;
          end else begin
            a_q <= diff[W-1:0];
          end
        end
        // quotient bits shift into x from the low end
        ST_DIVIDE: begin
          rem_q <= borrow ? opa[W-1:0] : diff[W-1:0];
          x_q   <= {x_q[W-2:0], ~borrow};
          if (cnt_q == '0) begin
            state_q <= ST_MULT;
          end else begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        ST_MULT: begin
          prod_q  <= prod_c;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = done_q;
  assign gcd_o       = g_q;
  assign lcm_o       = prod_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gcd_and_lcm_unit.sv =====
// gcd and lcm unit top level: request handshake, zero / equal shortcuts, result registers
// depends on gcdlcm_pkg and gcdlcm_core
//
// channel   direction  signals                                   handshake
// request   in         first_value_i, second_value_i             start & !busy
// result    out        common_divisor_o, common_multiple_o       done_o, one cycle
//
// zero or equal operands: result in the cycle after the request, busy stays low
// otherwise: the k shared factors of two are stripped, then the binary gcd steps run on
//   the shared subtractor, then W divide steps and the final multiply
// on the core path busy is high after the request until the result cycle; the receiver cannot stall
// rst_ni clears control state only
`default_nettype none

module gcd_and_lcm_unit #(
  parameter int OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [gcdlcm_pkg::FIELD_W-1:0]   first_value_i,
  input  wire logic [gcdlcm_pkg::FIELD_W-1:0]   second_value_i,
  output logic                                  done_o,
  output logic [gcdlcm_pkg::FIELD_W-1:0]        common_divisor_o,
  output logic [gcdlcm_pkg::PRODUCT_W-1:0]      common_multiple_o
);

  localparam int W        = OPERAND_WIDTH;
  localparam int FieldW   = gcdlcm_pkg::FIELD_W;
  localparam int ProductW = gcdlcm_pkg::PRODUCT_W;

  logic                   busy_q;
  logic                   done_q;
  logic [FieldW-1:0]      gcd_q;
  logic [ProductW-1:0]    lcm_q;

  logic [W-1:0]           a;
  logic [W-1:0]           b;
  logic                   accept;
  logic                   shortcut;
  logic                   core_start;
  gcdlcm_pkg::core_stat_t core_stat;
  logic [W-1:0]           core_gcd;
  logic [2*W-1:0]         core_lcm;

  assign a          = first_value_i[W-1:0];
  assign b          = second_value_i[W-1:0];
  assign accept     = start && !busy_q;
  assign shortcut   = (a == '0) || (b == '0) || (a == b);
  assign core_start = accept && !shortcut;

  gcdlcm_core #(
    .W (W)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .a_i     (a),
    .b_i     (b),
    .stat_o  (core_stat),
    .gcd_o   (core_gcd),
    .lcm_o   (core_lcm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (accept) begin
        if (shortcut) begin
          done_q <= 1'b1;
          if (a == '0) begin
            gcd_q <= FieldW'(b);
            lcm_q <= '0;
          end else if (b == '0) begin
            gcd_q <= FieldW'(a);
            lcm_q <= '0;
          end else begin
            gcd_q <= FieldW'(a);
            lcm_q <= ProductW'(a);
          end
        end else begin
          busy_q <= 1'b1;
        end
      end else if (core_stat.done) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        gcd_q  <= FieldW'(core_gcd);
        lcm_q  <= ProductW'(core_lcm);
      end
    end
  end

  assign busy              = busy_q;
  assign done_o            = done_q;
  assign common_divisor_o  = gcd_q;
  assign common_multiple_o = lcm_q;

`ifndef NO_ASSERTIONS
  a_core_done_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |-> busy_q)
    else $error("core finished without an open request");

  a_core_idle_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !core_stat.busy)
    else $error("request accepted while the core is working");

  a_result_frees_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q)
    else $error("result shown while the unit still reports busy");

  a_core_done_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |=> done_o && !busy_q)
    else $error("core result not delivered");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for gcd_and_lcm_unit: directed and random operand pairs,
// results checked against an in-bench gcd / lcm predictor
// depends on gcdlcm_pkg and the gcd_and_lcm_unit rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIELD_W   = gcdlcm_pkg::FIELD_W;
  localparam int PRODUCT_W = gcdlcm_pkg::PRODUCT_W;
  localparam int OPW = gcdlcm_pkg::OPERAND_WIDTH_DEF;
  localparam logic [PRODUCT_W-1:0] OPERAND_MASK = (64'd1 << OPW) - 64'd1;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [FIELD_W-1:0] first_op;
    logic [FIELD_W-1:0] second_op;
    bit                 drain;
  } operand_pair_t;

  typedef struct {
    logic [FIELD_W-1:0]   divisor;
    logic [PRODUCT_W-1:0] multiple;
  } gcd_lcm_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [FIELD_W-1:0]   first_value_i = '0;
  logic [FIELD_W-1:0]   second_value_i = '0;
  logic                 done_o;
  logic [FIELD_W-1:0]   common_divisor_o;
  logic [PRODUCT_W-1:0] common_multiple_o;

  operand_pair_t operand_requests[$];
  gcd_lcm_t      gcd_lcm_expected[$];

  operand_pair_t next_pair;
  gcd_lcm_t      oldest_result;
  bit            present_next;
  int unsigned   burst_left = 1;
  int unsigned   gap_left = 0;

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned requests_accepted = 0;
  int unsigned zero_requests = 0;
  int unsigned equal_requests = 0;
  int unsigned shared_factor_requests = 0;
  int unsigned wide_multiples = 0;

  gcd_and_lcm_unit #(
    .OPERAND_WIDTH(OPW)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .first_value_i    (first_value_i),
    .second_value_i   (second_value_i),
    .done_o           (done_o),
    .common_divisor_o (common_divisor_o),
    .common_multiple_o(common_multiple_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic gcd_lcm_t predict_gcd_lcm(input logic [FIELD_W-1:0] a_in,
                                               input logic [FIELD_W-1:0] b_in);
    logic [PRODUCT_W-1:0] a;
    logic [PRODUCT_W-1:0] b;
    logic [PRODUCT_W-1:0] x;
    logic [PRODUCT_W-1:0] y;
    logic [PRODUCT_W-1:0] r;
    gcd_lcm_t res;
    a = {32'd0, a_in} & OPERAND_MASK;
    b = {32'd0, b_in} & OPERAND_MASK;
    if (a == 0) begin
      res.divisor  = b[FIELD_W-1:0];
      res.multiple = '0;
    end else if (b == 0) begin
      res.divisor  = a[FIELD_W-1:0];
      res.multiple = '0;
    end else if (a == b) begin
      res.divisor  = a[FIELD_W-1:0];
      res.multiple = a;
    end else begin
      x = a;
      y = b;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.divisor  = x[FIELD_W-1:0];
      res.multiple = (a / x) * b;
    end
    return res;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_bits(input int unsigned nbits);
    if (nbits >= 32) return $urandom;
    return $urandom & ((32'd1 << nbits) - 32'd1);
  endfunction

  function automatic operand_pair_t random_pair();
    operand_pair_t p;
    int unsigned   gb;
    logic [FIELD_W-1:0] g;
    p.drain = 1'b0;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        p.first_op  = $urandom;
        p.second_op = $urandom;
      end
      3, 4: begin
        // common factor times two cofactors, kept within the operand width
        gb = $urandom_range(1, 31);
        g  = rand_bits(gb);
        if (g == 0) g = 1;
        p.first_op  = g * rand_bits($urandom_range(0, 32 - gb));
        p.second_op = g * rand_bits($urandom_range(0, 32 - gb));
      end
      5: begin
        p.first_op  = rand_bits($urandom_range(1, 32)) << $urandom_range(0, 31);
        p.second_op = rand_bits($urandom_range(1, 32)) << $urandom_range(0, 31);
      end
      6: begin
        p.first_op  = $urandom_range(0, 255);
        p.second_op = $urandom_range(0, 255);
      end
      7: begin
        if ($urandom_range(0, 1)) begin
          p.first_op  = '0;
          p.second_op = rand_bits($urandom_range(1, 32));
        end else begin
          p.first_op  = rand_bits($urandom_range(1, 32));
          p.second_op = '0;
        end
      end
      8: begin
        p.first_op  = $urandom >> $urandom_range(0, 31);
        p.second_op = p.first_op;
      end
      default: begin
        p.first_op  = $urandom >> $urandom_range(0, 31);
        p.second_op = $urandom >> $urandom_range(0, 31);
      end
    endcase
    return p;
  endfunction

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 4);
      2: return $urandom_range(5, 40);
      default: return $urandom_range(41, 250);
    endcase
  endfunction

  task automatic queue_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                            input bit drain);
    operand_pair_t p;
    p.first_op  = a;
    p.second_op = b;
    p.drain     = drain;
    operand_requests.push_back(p);
  endtask

  task automatic record_request(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    gcd_lcm_t res;
    res = predict_gcd_lcm(a, b);
    gcd_lcm_expected.push_back(res);
    requests_accepted++;
    if (a == 0 || b == 0) zero_requests++;
    else if (a == b) equal_requests++;
    else if (res.divisor != 1) shared_factor_requests++;
    if (res.multiple[PRODUCT_W-1:FIELD_W] != 0) wide_multiples++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      present_next = 1'b0;
      if (start && !busy) begin
        record_request(first_value_i, second_value_i);
      end
      if (start && busy) begin
        present_next = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (operand_requests.size() != 0 &&
                   !(operand_requests[0].drain &&
                     (start || done_o || gcd_lcm_expected.size() != 0))) begin
        next_pair = operand_requests.pop_front();
        first_value_i  <= next_pair.first_op;
        second_value_i <= next_pair.second_op;
        present_next = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = pick_gap();
        end
      end
      start <= present_next;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (gcd_lcm_expected.size() == 0) begin
        $error("result with no request pending: divisor %0h multiple %0h",
               common_divisor_o, common_multiple_o);
        mismatch_count++;
      end else begin
        oldest_result = gcd_lcm_expected.pop_front();
        results_checked++;
        if (common_divisor_o !== oldest_result.divisor) begin
          $error("common_divisor: expected %0h, actual %0h",
                 oldest_result.divisor, common_divisor_o);
          mismatch_count++;
        end
        if (common_multiple_o !== oldest_result.multiple) begin
          $error("common_multiple: expected %0h, actual %0h",
                 oldest_result.multiple, common_multiple_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    operand_pair_t fill_pair;
    queue_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    queue_pair(32'h0000_0000, 32'h0000_0001, 1'b0);
    queue_pair(32'h0000_0001, 32'h0000_0000, 1'b0);
    queue_pair(32'h0000_0001, 32'h0000_0001, 1'b0);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_pair(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    queue_pair(32'hFFFF_FFFB, 32'hFFFF_FFEF, 1'b0);
    queue_pair(32'h8000_0000, 32'h4000_0000, 1'b0);
    queue_pair(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    queue_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    queue_pair(32'd12, 32'd18, 1'b0);
    queue_pair(32'd18, 32'd12, 1'b0);
    queue_pair(32'hFFFF_0000, 32'h0000_FFFF, 1'b0);
    queue_pair(32'hFFFE_0000, 32'h0006_0000, 1'b0);
    queue_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      fill_pair = random_pair();
      // hold off until the unit has drained completely
      fill_pair.drain = (i == 0) || (i == RANDOM_REQUESTS / 2) ||
                        ($urandom_range(0, 199) == 0);
      operand_requests.push_back(fill_pair);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (operand_requests.size() != 0 || start || gcd_lcm_expected.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests: %0d with a zero operand, %0d equal pairs,",
             requests_accepted, zero_requests, equal_requests);
    $display("%0d with a shared factor, %0d results checked, %0d multiples wider than %0d bits",
             shared_factor_requests, results_checked, wide_multiples, FIELD_W);
    if (mismatch_count == 0 && gcd_lcm_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("timeout with %0d results outstanding", gcd_lcm_expected.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== gcd_and_lcm_unit.f =====
hw/rtl/gcdlcm_pkg.sv
hw/rtl/gcdlcm_core.sv
hw/rtl/gcd_and_lcm_unit.sv
tb/sv/testbench.sv
